// ===== rtl/core/sobel_gradient_nonmax_suppression_top_assert.svh =====
// ----------------------------------------------------------------------------
// Sobel gradient / non-maximum suppression assertion macros
// Concurrent assertion wrappers clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SOBEL_GRADIENT_NONMAX_SUPPRESSION_TOP_ASSERT_SVH
`define SOBEL_GRADIENT_NONMAX_SUPPRESSION_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define SGNMS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sgnms same-cycle check failed");
// Consequent must hold in the cycle after the antecedent.
`define SGNMS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sgnms next-cycle check failed");
`else
`define SGNMS_ASSERT_SAME(lbl, ante, cons)
`define SGNMS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/core/sgnms_pkg.sv =====
// ----------------------------------------------------------------------------
// sgnms_pkg
// Shared types, constants and arithmetic helpers of the Sobel / NMS block.
// ----------------------------------------------------------------------------
`default_nettype none

package sgnms_pkg;

    localparam int PIX_W       = 8;
    localparam int GRAD_W      = 8;
    localparam int MAG_W       = 9;
    localparam int DIR_W       = 2;
    localparam int SUM_W       = 10;
    localparam int REG_W       = 11;
    localparam int ROW_W       = 10;
    localparam int IDX_W       = 1;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 16;
    localparam int QCMP_W      = 18;

    localparam int FRAME_MIN        = 5;
    localparam int MAX_HEIGHT       = 1024;
    localparam int FRAME_WIDTH_RST  = 640;
    localparam int FRAME_HEIGHT_RST = 480;

    // tan(22.5 deg) and tan(67.5 deg) in Q8.
    localparam int TAN22_Q8 = 106;
    localparam int TAN67_Q8 = 618;

    localparam logic [GRAD_W-1:0] GRAD_MAX = 8'hFF;

    // Direction bins.
    localparam logic [DIR_W-1:0] DIR_HORZ = 2'd0;
    localparam logic [DIR_W-1:0] DIR_DIAG = 2'd1;
    localparam logic [DIR_W-1:0] DIR_VERT = 2'd2;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    // Position of a pixel inside the frame, as far as the datapath cares.
    typedef struct packed {
        logic c_ge1;
        logic c_ge2;
        logic c_ge4;
        logic r_ge2;
        logic r_ge4;
        logic last;
    } flags_t;

    // Hand-off from the gradient stage to the suppression stage.
    typedef struct packed {
        logic [GRAD_W-1:0] ax;
        logic [GRAD_W-1:0] ay;
        logic [DIR_W-1:0]  out_dir;
        logic [MAG_W-1:0]  mt;
        logic [MAG_W-1:0]  mm;
        flags_t            flags;
    } grad_t;

    // a + 2b + c of one Sobel row or column.
    function automatic logic [SUM_W-1:0] sum3(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b,
                                              input logic [PIX_W-1:0] c);
        return {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c};
    endfunction

    // |p - n| saturated to the gradient range.
    function automatic logic [GRAD_W-1:0] abs_clamp(input logic [SUM_W-1:0] p,
                                                    input logic [SUM_W-1:0] n);
        logic [SUM_W-1:0] d;
        d = (p >= n) ? (p - n) : (n - p);
        return (d > {2'b00, GRAD_MAX}) ? GRAD_MAX : d[GRAD_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sgnms_line_ram.sv =====
// ----------------------------------------------------------------------------
// sgnms_line_ram
// Simple dual-port line buffer: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module sgnms_line_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/sgnms_sobel.sv =====
// ----------------------------------------------------------------------------
// sgnms_sobel
// 3x3 Sobel gradient stage with the pixel column window and pixel line write.
// ----------------------------------------------------------------------------
`default_nettype none

module sgnms_sobel
    import sgnms_pkg::*;
#(
    parameter int COL_W = 10
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       advance,
    input  wire logic [PIX_W-1:0]           pixel,
    input  wire flags_t                     flags,
    input  wire logic [COL_W-1:0]           col,
    input  wire logic [2*PIX_W-1:0]         line_data,
    input  wire logic [DIR_W+2*MAG_W-1:0]   mag_line_data,
    output grad_t                           grad,
    output logic                            pix_wr_en,
    output logic [COL_W-1:0]                pix_wr_addr,
    output logic [2*PIX_W-1:0]              pix_wr_data
);

    // Window: left and center pixel columns plus one held direction bin.
    logic [PIX_W-1:0] left_t_reg, left_m_reg, left_b_reg;
    logic [PIX_W-1:0] ctr_t_reg, ctr_m_reg, ctr_b_reg;
    logic [DIR_W-1:0] held_dir_reg, held_dir_next;

    logic [PIX_W-1:0]  pt, pm, pb;
    logic [SUM_W-1:0]  right_sum, left_sum, top_sum, bot_sum;
    logic [GRAD_W-1:0] gx, gy;
    logic              active;

    assign pt = line_data[2*PIX_W-1:PIX_W];
    assign pm = line_data[PIX_W-1:0];
    assign pb = pixel;

    assign right_sum = sum3(pt, pm, pb);
    assign left_sum  = sum3(left_t_reg, left_m_reg, left_b_reg);
    assign top_sum   = sum3(left_t_reg, ctr_t_reg, pt);
    assign bot_sum   = sum3(left_b_reg, ctr_b_reg, pb);

    assign gx     = abs_clamp(right_sum, left_sum);
    assign gy     = abs_clamp(top_sum, bot_sum);
    assign active = flags.r_ge2 & flags.c_ge2;

    always_comb
    begin
        grad.ax      = active ? gx : '0;
        grad.ay      = active ? gy : '0;
        grad.out_dir = held_dir_reg;
        grad.mt      = flags.c_ge1 ? mag_line_data[2*MAG_W-1:MAG_W] : '0;
        grad.mm      = flags.c_ge1 ? mag_line_data[MAG_W-1:0] : '0;
        grad.flags   = flags;
        held_dir_next = flags.c_ge1 ? mag_line_data[DIR_W+2*MAG_W-1:2*MAG_W]
                                    : held_dir_reg;
    end

    // The older line takes the middle row, the newer line takes this pixel.
    assign pix_wr_en   = advance;
    assign pix_wr_addr = col;
    assign pix_wr_data = {pm, pb};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_t_reg   <= '0;
            left_m_reg   <= '0;
            left_b_reg   <= '0;
            ctr_t_reg    <= '0;
            ctr_m_reg    <= '0;
            ctr_b_reg    <= '0;
            held_dir_reg <= '0;
        end
        else if (advance)
        begin
            left_t_reg   <= ctr_t_reg;
            left_m_reg   <= ctr_m_reg;
            left_b_reg   <= ctr_b_reg;
            ctr_t_reg    <= pt;
            ctr_m_reg    <= pm;
            ctr_b_reg    <= pb;
            held_dir_reg <= held_dir_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/sgnms_nms.sv =====
// ----------------------------------------------------------------------------
// sgnms_nms
// Magnitude, direction binning, non-maximum suppression and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sgnms_nms
    import sgnms_pkg::*;
#(
    parameter int COL_W = 10
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       load,
    input  wire grad_t                      grad_in,
    input  wire logic [COL_W-1:0]           col_in,
    output logic                            s2_ready,
    output logic                            mag_wr_en,
    output logic [COL_W-1:0]                mag_wr_addr,
    output logic [DIR_W+2*MAG_W-1:0]        mag_wr_data,
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    output logic [OUT_TDATA_W-1:0]          m_axis_tdata,  // [8:0] edge_magnitude, [10:9] edge_direction
    output logic                            m_axis_tlast   // frame_end
);

    logic              s2_valid_reg;
    grad_t             s2_reg;
    logic [COL_W-1:0]  s2_col_reg;

    // Magnitude window: left and center columns. The bottom of the left
    // column is never a neighbor, so it is not kept.
    logic [MAG_W-1:0] at_reg, am_reg;
    logic [MAG_W-1:0] bt_reg, bm_reg, bb_reg;

    logic              out_valid_reg;
    logic [MAG_W-1:0]  out_mag_reg;
    logic [DIR_W-1:0]  out_dir_reg;
    logic              out_last_reg;

    logic [MAG_W-1:0]  mag;
    logic [DIR_W-1:0]  dir;
    logic [QCMP_W-1:0] ay_q, lo_lim, hi_lim;
    logic [MAG_W-1:0]  n1, n2;
    logic [MAG_W-1:0]  em;
    logic [DIR_W-1:0]  ed;
    logic              produce, compare_on, out_free, s2_fire;

    assign mag    = {1'b0, s2_reg.ax} + {1'b0, s2_reg.ay};
    assign ay_q   = QCMP_W'({s2_reg.ay, 8'h00});
    assign lo_lim = QCMP_W'(s2_reg.ax) * QCMP_W'(TAN22_Q8);
    assign hi_lim = QCMP_W'(s2_reg.ax) * QCMP_W'(TAN67_Q8);

    always_comb
    begin
        if (ay_q <= lo_lim)
        begin
            dir = DIR_HORZ;
        end
        else if (ay_q > hi_lim)
        begin
            dir = DIR_VERT;
        end
        else
        begin
            dir = DIR_DIAG;
        end
    end

    // Neighbors along the held direction of the center pixel.
    always_comb
    begin
        case (s2_reg.out_dir)
            DIR_HORZ:
            begin
                n1 = am_reg;
                n2 = s2_reg.mm;
            end
            DIR_VERT:
            begin
                n1 = bt_reg;
                n2 = bb_reg;
            end
            default:
            begin
                n1 = at_reg;
                n2 = mag;
            end
        endcase
    end

    assign produce    = s2_reg.flags.r_ge2 & s2_reg.flags.c_ge2;
    assign compare_on = s2_reg.flags.r_ge4 & s2_reg.flags.c_ge4;
    assign em = (compare_on && (bm_reg >= n1) && (bm_reg >= n2)) ? bm_reg : '0;
    assign ed = compare_on ? s2_reg.out_dir : DIR_HORZ;

    assign out_free = !out_valid_reg || m_axis_tready;
    assign s2_fire  = s2_valid_reg && (!produce || out_free);
    assign s2_ready = !s2_valid_reg || s2_fire;

    assign mag_wr_en   = s2_fire && s2_reg.flags.c_ge1;
    assign mag_wr_addr = s2_col_reg - COL_W'(1);
    assign mag_wr_data = {dir, s2_reg.mm, mag};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            s2_valid_reg <= 1'b1;
        end
        else if (s2_fire)
        begin
            s2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s2_reg     <= grad_in;
            s2_col_reg <= col_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            at_reg <= '0;
            am_reg <= '0;
            bt_reg <= '0;
            bm_reg <= '0;
            bb_reg <= '0;
        end
        else if (s2_fire)
        begin
            at_reg <= bt_reg;
            am_reg <= bm_reg;
            bt_reg <= s2_reg.mt;
            bm_reg <= s2_reg.mm;
            bb_reg <= mag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s2_fire && produce)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_fire && produce)
        begin
            out_mag_reg  <= em;
            out_dir_reg  <= ed;
            out_last_reg <= s2_reg.flags.last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'({out_dir_reg, out_mag_reg});
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ===== rtl/core/sobel_gradient_nonmax_suppression_top.sv =====
// ----------------------------------------------------------------------------
// sobel_gradient_nonmax_suppression_top
// Streaming 3x3 Sobel gradient with direction binning and non-maximum
// suppression on a raster stream of 8-bit pixels.
// ----------------------------------------------------------------------------
//
//  Channel   Side    Payload                                   Request taken when
//  -------   -----   ---------------------------------------   -------------------------
//  s_axis    in      tdata[7:0] pixel                          tvalid & tready
//  m_axis    out     tdata[8:0] magnitude, [10:9] direction,   tvalid & tready
//                    tlast frame_end
//  cfg       in      index 0 frame_width, 1 frame_height       cfg_we
//
// One pixel is taken per clock cycle unless a stall on m_axis holds the flow. Its
// result reaches the output register in order: the accepting edge fills the input
// register and reads the line buffers, then the pixel loads the gradient stage, and
// then its result loads the output register. Reset clears the counters, column windows
// and valid flags; the line buffers start unwritten. A stall on m_axis only holds a
// result request in flight, while pixels that give no result keep moving.
//
// ----------------------------------------------------------------------------
`default_nettype none

`include "sobel_gradient_nonmax_suppression_top_assert.svh"

module sobel_gradient_nonmax_suppression_top
    import sgnms_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // Configuration write port.
    input  wire logic                   cfg_we,
    input  wire logic [IDX_W-1:0]       cfg_index,
    input  wire logic [REG_W-1:0]       cfg_data,
    // Pixel stream in.
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] pixel
    // Edge stream out.
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,   // [8:0] edge_magnitude, [10:9] edge_direction
    output logic                        m_axis_tlast    // frame_end
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int CMP_W  = (REG_W > COL_W) ? REG_W + 1 : COL_W + 1;
    localparam int LAST_COL_RST =
        ((FRAME_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RST) - 1;
    localparam int LAST_ROW_RST = FRAME_HEIGHT_RST - 1;

    // Frame geometry, held as the last column and row index after clamping.
    logic [COL_W-1:0] last_col_reg, last_col_next;
    logic [ROW_W-1:0] last_row_reg, last_row_next;
    logic [CMP_W-1:0] width_ext;

    // Position of the next pixel.
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    // Input register stage: pixel plus its position; line data sits in the RAMs.
    logic             s1_valid_reg;
    logic [PIX_W-1:0] s1_pixel_reg;
    logic [COL_W-1:0] s1_col_reg;
    flags_t           s1_flags_reg;
    flags_t           in_flags;

    logic accept, s1_fire, s2_ready;

    logic [2*PIX_W-1:0]       pix_rd_data, pix_wr_data;
    logic [COL_W-1:0]         pix_wr_addr;
    logic                     pix_wr_en;
    logic [DIR_W+2*MAG_W-1:0] mag_rd_data, mag_wr_data;
    logic [COL_W-1:0]         mag_wr_addr, mag_rd_addr;
    logic                     mag_wr_en;
    grad_t                    grad;

    // ---------------------------------------------------------------- config
    // Width clamps to [5, MAX_WIDTH], height to [5, 1024].
    assign width_ext = CMP_W'(cfg_data);

    always_comb
    begin
        last_col_next = last_col_reg;
        last_row_next = last_row_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:
                begin
                    if (width_ext < CMP_W'(FRAME_MIN))
                    begin
                        last_col_next = COL_W'(FRAME_MIN - 1);
                    end
                    else if (width_ext > CMP_W'(MAX_WIDTH))
                    begin
                        last_col_next = COL_W'(MAX_WIDTH - 1);
                    end
                    else
                    begin
                        last_col_next = COL_W'(width_ext - CMP_W'(1));
                    end
                end
                REG_FRAME_HEIGHT:
                begin
                    if (cfg_data < REG_W'(FRAME_MIN))
                    begin
                        last_row_next = ROW_W'(FRAME_MIN - 1);
                    end
                    else if (cfg_data > REG_W'(MAX_HEIGHT))
                    begin
                        last_row_next = ROW_W'(MAX_HEIGHT - 1);
                    end
                    else
                    begin
                        last_row_next = ROW_W'(cfg_data - REG_W'(1));
                    end
                end
                default:
                begin
                    last_col_next = last_col_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_col_reg <= COL_W'(LAST_COL_RST);
            last_row_reg <= ROW_W'(LAST_ROW_RST);
        end
        else
        begin
            last_col_reg <= last_col_next;
            last_row_reg <= last_row_next;
        end
    end

    // ------------------------------------------------------ position counters
    assign s1_fire       = s1_valid_reg && s2_ready;
    assign s_axis_tready = !s1_valid_reg || s2_ready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_we)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (col_reg == last_col_reg)
            begin
                col_next = '0;
                row_next = (row_reg == last_row_reg) ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_comb
    begin
        in_flags.c_ge1 = (col_reg != '0);
        in_flags.c_ge2 = (col_reg >= COL_W'(2));
        in_flags.c_ge4 = (col_reg >= COL_W'(4));
        in_flags.r_ge2 = (row_reg >= ROW_W'(2));
        in_flags.r_ge4 = (row_reg >= ROW_W'(4));
        in_flags.last  = (col_reg == last_col_reg) && (row_reg == last_row_reg);
    end

    // The magnitude line is kept one column behind the pixel line.
    assign mag_rd_addr = (col_reg == '0) ? '0 : col_reg - COL_W'(1);

    // ------------------------------------------------------ input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pixel_reg <= s_axis_tdata[PIX_W-1:0];
            s1_col_reg   <= col_reg;
            s1_flags_reg <= in_flags;
        end
    end

    // ------------------------------------------------------ line buffers
    // Pixel line entry: {row r-2, row r-1}.
    sgnms_line_ram #(
        .DATA_W (2*PIX_W),
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (COL_W)
    ) u_pixel_ram (
        .clk     (clk),
        .wr_en   (pix_wr_en),
        .wr_addr (pix_wr_addr),
        .wr_data (pix_wr_data),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (pix_rd_data)
    );

    // Magnitude line entry: {direction bin, older magnitude, newer magnitude}.
    sgnms_line_ram #(
        .DATA_W (DIR_W + 2*MAG_W),
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (COL_W)
    ) u_mag_ram (
        .clk     (clk),
        .wr_en   (mag_wr_en),
        .wr_addr (mag_wr_addr),
        .wr_data (mag_wr_data),
        .rd_en   (accept),
        .rd_addr (mag_rd_addr),
        .rd_data (mag_rd_data)
    );

    // ------------------------------------------------------ datapath stages
    sgnms_sobel #(
        .COL_W (COL_W)
    ) u_sobel (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (s1_fire),
        .pixel         (s1_pixel_reg),
        .flags         (s1_flags_reg),
        .col           (s1_col_reg),
        .line_data     (pix_rd_data),
        .mag_line_data (mag_rd_data),
        .grad          (grad),
        .pix_wr_en     (pix_wr_en),
        .pix_wr_addr   (pix_wr_addr),
        .pix_wr_data   (pix_wr_data)
    );

    sgnms_nms #(
        .COL_W (COL_W)
    ) u_nms (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (s1_fire),
        .grad_in       (grad),
        .col_in        (s1_col_reg),
        .s2_ready      (s2_ready),
        .mag_wr_en     (mag_wr_en),
        .mag_wr_addr   (mag_wr_addr),
        .mag_wr_data   (mag_wr_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // ------------------------------------------------------ assertions
    // The position never runs past the configured frame.
    `SGNMS_ASSERT_SAME(a_pos_in_frame, 1'b1, (col_reg <= last_col_reg) && (row_reg <= last_row_reg))
    // A configuration write restarts the frame.
    `SGNMS_ASSERT_NEXT(a_cfg_restart, cfg_we, (col_reg == '0) && (row_reg == '0))
    // A pixel held in the input register waits there until the next stage frees up.
    `SGNMS_ASSERT_NEXT(a_s1_hold, s1_valid_reg && !s2_ready, s1_valid_reg && $stable(s1_pixel_reg))

endmodule

`default_nettype wire

// ===== tb/sobel_gradient_nonmax_suppression_top_tb.sv =====
// ----------------------------------------------------------------------------
// Sobel gradient / non-maximum suppression testbench
// Streams raster frames of 8-bit pixels into the block under several frame
// geometries and idling patterns. An in-bench predictor of the Sobel gradient,
// direction binning and suppression works out each edge result, and every
// result leaving the block is compared field by field in arrival order.
// ----------------------------------------------------------------------------
`default_nettype none

module sobel_gradient_nonmax_suppression_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sgnms_pkg::*;

    localparam int MAX_W       = 1024;
    localparam int RESULT_LAG  = 8;        // generous over the three-stage pipe
    localparam int CYCLE_LIMIT = 400000;
    localparam int RESET_PIXELS   = 40;
    localparam int EXTREME_PIXELS = 60;
    localparam int RANDOM_PIXELS  = 725;

    typedef struct packed {
        logic [MAG_W-1:0] mag;
        logic [DIR_W-1:0] dir;
        logic             last;
    } edge_t;

    typedef enum int {PAT_UNIFORM, PAT_BINARY, PAT_RAMP, PAT_STRIPES, PAT_CORNER} pattern_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [IDX_W-1:0]       cfg_index;
    logic [REG_W-1:0]       cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;    // [7:0] pixel
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;    // [8:0] edge_magnitude, [10:9] edge_direction
    logic                   m_axis_tlast;    // frame_end

    sobel_gradient_nonmax_suppression_top #(
        .MAX_WIDTH(MAX_W)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast)
    );

    // Stimulus bookkeeping.
    logic [7:0] pixel_queue [$];
    edge_t      expected_edges [$];
    int         pixels_sent;
    int         pixels_taken;
    int         edges_checked;
    int         error_count;
    int         cycle_count;
    logic       pixel_taken;
    int         sender_idle_pct;
    int         receiver_stall_pct;

    // Pattern of the frame being generated.
    pattern_t   pat_mode;
    int         pat_base, pat_dx, pat_dy, pat_noise, pat_hi, pat_lo;

    // Predictor state: frame registers, line stores, position and windows.
    int         width_reg;
    int         height_reg;
    logic [7:0]       pix_line [2][MAX_W];
    logic [MAG_W-1:0] mag_line [2][MAX_W];
    logic [DIR_W-1:0] dir_line [MAX_W];
    int         row_pos;
    int         col_pos;
    logic [7:0]       pix_left [3];
    logic [7:0]       pix_mid  [3];
    logic [MAG_W-1:0] mag_left [3];
    logic [MAG_W-1:0] mag_mid  [3];
    logic [DIR_W-1:0] held_dir;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int frame_dim(input int v, input int hi);
        return (v < FRAME_MIN) ? FRAME_MIN : ((v > hi) ? hi : v);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        $display("result %0d: %s is %0d, expected %0d", edges_checked, what, got, want);
    endtask

    // Advances the predictor by one accepted pixel and queues the edge result,
    // if this pixel position produces one.
    task automatic predict_edge(input logic [7:0] px);
        int w, h, r, c;
        int pt, pm, pb, gx, gy, ax, ay;
        int mag, mt, mm, mb, n1, n2;
        logic [DIR_W-1:0] dir, out_dir;
        edge_t res;
        w = frame_dim(width_reg, MAX_W);
        h = frame_dim(height_reg, MAX_HEIGHT);
        r = (row_pos >= h) ? 0 : row_pos;
        c = (col_pos >= w) ? 0 : col_pos;

        // Pixel column at c holds rows r-2, r-1 and the new pixel at r.
        pt = int'(pix_line[1][c]);
        pm = int'(pix_line[0][c]);
        pb = int'(px);
        pix_line[1][c] = 8'(pm);
        pix_line[0][c] = 8'(pb);

        mag = 0;
        dir = DIR_HORZ;
        if (r >= 2 && c >= 2)
        begin
            gx = (pt + 2 * pm + pb) - (pix_left[0] + 2 * pix_left[1] + pix_left[2]);
            gy = (pix_left[0] + 2 * pix_mid[0] + pt) - (pix_left[2] + 2 * pix_mid[2] + pb);
            ax = (gx < 0) ? -gx : gx;
            ay = (gy < 0) ? -gy : gy;
            if (ax > 255) ax = 255;
            if (ay > 255) ay = 255;
            mag = ax + ay;
            // Ties fall into the lower bin; a flat patch lands in the horizontal bin.
            if (ay * 256 <= TAN22_Q8 * ax)
                dir = DIR_HORZ;
            else if (ay * 256 > TAN67_Q8 * ax)
                dir = DIR_VERT;
            else
                dir = DIR_DIAG;
        end

        // Magnitude column at c-1 holds rows r-3, r-2 and the fresh magnitude.
        mt = 0;
        mm = 0;
        mb = mag;
        out_dir = held_dir;
        if (c >= 1)
        begin
            mt = int'(mag_line[1][c-1]);
            mm = int'(mag_line[0][c-1]);
            mag_line[1][c-1] = MAG_W'(mm);
            mag_line[0][c-1] = MAG_W'(mag);
            held_dir = dir_line[c-1];
            dir_line[c-1] = dir;
        end

        if (r >= 2 && c >= 2)
        begin
            res = '0;
            // Pixels within two of the frame edge are border and stay zero.
            if (r >= 4 && c >= 4)
            begin
                case (out_dir)
                    DIR_HORZ:
                    begin
                        n1 = int'(mag_left[1]);
                        n2 = mm;
                    end
                    DIR_VERT:
                    begin
                        n1 = int'(mag_mid[0]);
                        n2 = int'(mag_mid[2]);
                    end
                    default:
                    begin
                        n1 = int'(mag_left[0]);
                        n2 = mb;
                    end
                endcase
                res.dir = out_dir;
                if (int'(mag_mid[1]) >= n1 && int'(mag_mid[1]) >= n2)
                    res.mag = mag_mid[1];
            end
            res.last = (r == h - 1 && c == w - 1);
            expected_edges.push_back(res);
        end

        for (int k = 0; k < 3; k++)
        begin
            pix_left[k] = pix_mid[k];
            mag_left[k] = mag_mid[k];
        end
        pix_mid[0] = 8'(pt);
        pix_mid[1] = 8'(pm);
        pix_mid[2] = 8'(pb);
        mag_mid[0] = MAG_W'(mt);
        mag_mid[1] = MAG_W'(mm);
        mag_mid[2] = MAG_W'(mb);

        c++;
        if (c >= w)
        begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        row_pos = r;
        col_pos = c;
    endtask

    function automatic logic [7:0] make_pixel(input int r, input int c);
        int v;
        case (pat_mode)
            PAT_UNIFORM: v = int'($urandom_range(255));
            PAT_BINARY:  v = $urandom_range(1) ? 255 : 0;
            PAT_RAMP:    v = pat_base + r * pat_dy + c * pat_dx
                             + int'($urandom_range(2 * pat_noise)) - pat_noise;
            PAT_STRIPES: v = (((r * (pat_dy + 40) + c * (pat_dx + 40)) / 32) % 2 == 1)
                             ? pat_hi : pat_lo;
            default:     v = (r < 3 && c < 3) ? 0 : 255;
        endcase
        return (v < 0) ? 8'd0 : ((v > 255) ? 8'd255 : v[7:0]);
    endfunction

    task automatic new_pattern();
        pat_mode  = pattern_t'($urandom_range(3));
        pat_base  = $urandom_range(255);
        pat_dx    = int'($urandom_range(80)) - 40;
        pat_dy    = int'($urandom_range(80)) - 40;
        pat_noise = $urandom_range(12);
        pat_hi    = $urandom_range(255);
        pat_lo    = $urandom_range(255);
    endtask

    task automatic push_pixels(input int w, input int h, input int first, input int count);
        @(posedge clk);
        for (int i = first; i < first + count; i++)
        begin
            pixel_queue.push_back(make_pixel((i / w) % h, i % w));
            pixels_sent++;
        end
    endtask

    // Blocks until every pixel is taken and every predicted edge has arrived.
    task automatic wait_drain();
        do
            @(negedge clk);
        while (pixels_taken != pixels_sent || expected_edges.size() != 0);
    endtask

    // Pixels at the frame border give no result and may still be in the pipe.
    task automatic wait_idle();
        wait_drain();
        repeat (RESULT_LAG) @(negedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input int value);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[REG_W-1:0];
        if (idx == REG_FRAME_WIDTH)
            width_reg = value & 32'h7FF;
        else
            height_reg = value & 32'h7FF;
        row_pos = 0;
        col_pos = 0;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_idling(input int phase_no);
        case (phase_no % 4)
            0:
            begin
                sender_idle_pct    = 0;
                receiver_stall_pct = 0;
            end
            1:
            begin
                sender_idle_pct    = 48;
                receiver_stall_pct = 0;
            end
            2:
            begin
                sender_idle_pct    = 0;
                receiver_stall_pct = 48;
            end
            default:
            begin
                sender_idle_pct    = 7;
                receiver_stall_pct = 7;
            end
        endcase
    endtask

    // Driver: inputs change on the falling edge. A pixel stays on the bus
    // until the block takes it.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
            if (!s_axis_tvalid || pixel_taken)
            begin
                if (pixel_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= pixel_queue.pop_front();
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: requests on both sides are sampled on the rising edge.
    always @(posedge clk)
    begin : monitor_proc
        edge_t want;
        if (rst_n)
        begin
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
            else
            begin
                pixel_taken <= s_axis_tvalid && s_axis_tready;
                if (s_axis_tvalid && s_axis_tready)
                begin
                    pixels_taken++;
                    predict_edge(s_axis_tdata);
                end
                if (m_axis_tvalid && m_axis_tready)
                begin
                    if (expected_edges.size() == 0)
                    begin
                        report_mismatch("unexpected result tdata", m_axis_tdata, 0);
                    end
                    else
                    begin
                        want = expected_edges.pop_front();
                        if (m_axis_tdata[8:0] !== want.mag)
                            report_mismatch("edge_magnitude", m_axis_tdata[8:0], want.mag);
                        if (m_axis_tdata[10:9] !== want.dir)
                            report_mismatch("edge_direction", m_axis_tdata[10:9], want.dir);
                        if (m_axis_tlast !== want.last)
                            report_mismatch("frame_end", m_axis_tlast, want.last);
                        if (m_axis_tdata[15:11] !== 5'd0)
                            report_mismatch("tdata padding", m_axis_tdata[15:11], 0);
                    end
                    edges_checked++;
                end
            end
        end
    end

    initial
    begin
        int w_val, h_val, w_eff, h_eff, total, rand_pixels, phase_no;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_FRAME_WIDTH;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        pixel_taken   = 1'b0;
        pixels_sent   = 0;
        pixels_taken  = 0;
        edges_checked = 0;
        error_count   = 0;
        cycle_count   = 0;
        width_reg     = FRAME_WIDTH_RST;
        height_reg    = FRAME_HEIGHT_RST;
        row_pos       = 0;
        col_pos       = 0;
        held_dir      = DIR_HORZ;
        for (int k = 0; k < 3; k++)
        begin
            pix_left[k] = '0;
            pix_mid[k]  = '0;
            mag_left[k] = '0;
            mag_mid[k]  = '0;
        end
        for (int i = 0; i < MAX_W; i++)
        begin
            pix_line[0][i] = '0;
            pix_line[1][i] = '0;
            mag_line[0][i] = '0;
            mag_line[1][i] = '0;
            dir_line[i]    = DIR_HORZ;
        end
        set_idling(0);
        new_pattern();

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset geometry: a stretch of the first row of the default frame
        // must give no result before any configuration is written.
        pat_mode = PAT_UNIFORM;
        push_pixels(FRAME_WIDTH_RST, FRAME_HEIGHT_RST, 0, RESET_PIXELS);

        // Smallest frame: a dark corner against full white gives saturated
        // gradients, flat patches and the border ring in one frame.
        write_reg(REG_FRAME_WIDTH, FRAME_MIN);
        write_reg(REG_FRAME_HEIGHT, FRAME_MIN);
        pat_mode = PAT_CORNER;
        push_pixels(FRAME_MIN, FRAME_MIN, 0, FRAME_MIN * FRAME_MIN);

        // Register extremes: a zero width clamps up to the minimum and an
        // oversized height clamps down, shown over the first rows of the frame.
        set_idling(3);
        write_reg(REG_FRAME_WIDTH, 0);
        write_reg(REG_FRAME_HEIGHT, 2047);
        new_pattern();
        push_pixels(FRAME_MIN, MAX_HEIGHT, 0, EXTREME_PIXELS);

        // Random small frames; some are cut short and restarted by the next write.
        rand_pixels = 0;
        phase_no = 0;
        while (rand_pixels < RANDOM_PIXELS)
        begin
            set_idling(phase_no);
            w_val = $urandom_range(14, 3);
            h_val = $urandom_range(12, 3);
            if ($urandom_range(1))
            begin
                write_reg(REG_FRAME_WIDTH, w_val);
                write_reg(REG_FRAME_HEIGHT, h_val);
            end
            else
            begin
                write_reg(REG_FRAME_HEIGHT, h_val);
                write_reg(REG_FRAME_WIDTH, w_val);
            end
            w_eff = frame_dim(w_val, MAX_W);
            h_eff = frame_dim(h_val, MAX_HEIGHT);
            new_pattern();
            total = w_eff * h_eff * (1 + $urandom_range(1));
            if ($urandom_range(3) == 0)
                total = $urandom_range(total - 1, 1);
            if (total > RANDOM_PIXELS - rand_pixels)
                total = RANDOM_PIXELS - rand_pixels;
            if (phase_no == 1)
            begin
                // Hold the stream mid-frame until the block has emptied.
                push_pixels(w_eff, h_eff, 0, total / 2);
                wait_drain();
                push_pixels(w_eff, h_eff, total / 2, total - total / 2);
            end
            else
            begin
                push_pixels(w_eff, h_eff, 0, total);
            end
            rand_pixels += total;
            phase_no++;
        end

        wait_idle();
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sobel_gradient_nonmax_suppression_top.f =====
+incdir+rtl/core
rtl/core/sgnms_pkg.sv
rtl/core/sgnms_line_ram.sv
rtl/core/sgnms_sobel.sv
rtl/core/sgnms_nms.sv
rtl/core/sobel_gradient_nonmax_suppression_top.sv
tb/sobel_gradient_nonmax_suppression_top_tb.sv
